>>> rtl/window_center_average_filter_unit_macros.svh
// Assertion macros for the window centre average filter RTL.
`ifndef WINDOW_CENTER_AVERAGE_FILTER_UNIT_MACROS_SVH
`define WINDOW_CENTER_AVERAGE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define WCAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define WCAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/wcaf_pkg.sv
// Shared types and constants of the window centre average filter.
`default_nettype none

package wcaf_pkg;

    localparam int WCAF_DEFAULT_WINDOW_DEPTH = 64;
    localparam int WCAF_DEFAULT_SAMPLE_BITS  = 12;
    localparam int WCAF_CENTER_COUNT         = 5;
    localparam int WCAF_CENTER_HALF          = 2;

    // comparison of a cell's value against the evicted and the incoming sample
    typedef struct packed {
        logic gt_old;
        logic gt_new;
        logic lt_old;
        logic lt_new;
    } wcaf_flags_t;

    // broadcast to every cell
    typedef struct packed {
        logic update;
        logic new_ge_old;
    } wcaf_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANK,
        S_SUM,
        S_MUL,
        S_OUT
    } wcaf_state_t;

endpackage

`default_nettype wire

>>> rtl/wcaf_cell.sv
// One cell of the sorted chain: holds one ranked window value.
`default_nettype none

module wcaf_cell #(
    parameter int SAMPLE_BITS = wcaf_pkg::WCAF_DEFAULT_SAMPLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire wcaf_pkg::wcaf_ctrl_t   ctrl,
    input  wire logic [SAMPLE_BITS-1:0] old_value,
    input  wire logic [SAMPLE_BITS-1:0] new_value,
    input  wire logic                   has_left,
    input  wire logic [SAMPLE_BITS-1:0] left_value,
    input  wire wcaf_pkg::wcaf_flags_t  left_flags,
    input  wire logic                   has_right,
    input  wire logic [SAMPLE_BITS-1:0] right_value,
    input  wire wcaf_pkg::wcaf_flags_t  right_flags,
    output logic [SAMPLE_BITS-1:0]      value,
    output wcaf_pkg::wcaf_flags_t       flags
);

    logic [SAMPLE_BITS-1:0] value_reg;
    logic [SAMPLE_BITS-1:0] value_next;

    always_comb
    begin
        flags.gt_old = value_reg > old_value;
        flags.gt_new = value_reg > new_value;
        flags.lt_old = value_reg < old_value;
        flags.lt_new = value_reg < new_value;
    end

    // Remove one copy of the evicted value, insert the new one.
    // New at or above old: the run between them moves one cell down.
    // New below old: the run between them moves one cell up.
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.new_ge_old)
        begin
            priority if (flags.gt_new)
                value_next = value_reg;
            else if (!has_right || right_flags.gt_new)
                value_next = new_value;
            else if (right_flags.gt_old)
                value_next = right_value;
            else
                value_next = value_reg;
        end
        else
        begin
            priority if (flags.lt_new)
                value_next = value_reg;
            else if (!has_left || left_flags.lt_new)
                value_next = new_value;
            else if (left_flags.lt_old)
                value_next = left_value;
            else
                value_next = value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= '0;
        else if (ctrl.update)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

>>> rtl/window_center_average_filter_unit.sv
// Window centre average filter: ranks the last WINDOW_DEPTH samples in a
// sorted chain of cells and returns the truncated mean of the middle five.
// One sample is in work at a time: it is accepted, then the sorted chain
// drops the sample that leaves the window and takes the new one, the five
// centre cells are summed, and the sum is divided by five through a
// reciprocal multiply. The sequencer steps through the window memory read,
// the chain update, the centre sum, the multiply and the output load; a
// new sample is taken only once the result of the last one is loaded into
// the output register, and that load waits while the output side stalls.
// The window starts as all zeros after reset with no clearing pass: until
// the first lap is complete the evicted value is taken as zero.
`default_nettype none

`include "window_center_average_filter_unit_macros.svh"

module window_center_average_filter_unit #(
    parameter int WINDOW_DEPTH = wcaf_pkg::WCAF_DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = wcaf_pkg::WCAF_DEFAULT_SAMPLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [SAMPLE_BITS-1:0]      filtered
);

    localparam int SLOT_BITS   = $clog2(WINDOW_DEPTH);
    localparam int MID         = WINDOW_DEPTH / 2;
    localparam int SUM_BITS    = SAMPLE_BITS + 3;
    localparam int RECIP_SHIFT = SUM_BITS + 2;
    localparam int PROD_BITS   = 2 * SUM_BITS;
    localparam logic [SUM_BITS-1:0] RECIP =
        SUM_BITS'(((2 ** RECIP_SHIFT) + wcaf_pkg::WCAF_CENTER_COUNT - 1)
                  / wcaf_pkg::WCAF_CENTER_COUNT);
    localparam logic [SUM_BITS-1:0] DIVISOR = SUM_BITS'(wcaf_pkg::WCAF_CENTER_COUNT);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_DEPTH - 1);

    wcaf_pkg::wcaf_state_t state_reg;
    wcaf_pkg::wcaf_state_t state_next;

    logic [SAMPLE_BITS-1:0] window_mem [WINDOW_DEPTH];
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SLOT_BITS-1:0]   slot_next;
    logic                   filled_reg;
    logic                   filled_next;
    logic                   old_known_reg;
    logic [SAMPLE_BITS-1:0] old_read_reg;
    logic [SAMPLE_BITS-1:0] new_reg;
    logic [SAMPLE_BITS-1:0] old_value;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [SAMPLE_BITS-1:0] quotient;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_reg;

    logic accept;
    logic out_free;
    logic load_sum;
    logic load_prod;
    logic load_out;

    wcaf_pkg::wcaf_ctrl_t  ctrl;
    logic [SAMPLE_BITS-1:0] cell_value [WINDOW_DEPTH];
    wcaf_pkg::wcaf_flags_t  cell_flags [WINDOW_DEPTH];

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wcaf_pkg::S_IDLE: if (in_valid) state_next = wcaf_pkg::S_RANK;
            wcaf_pkg::S_RANK: state_next = wcaf_pkg::S_SUM;
            wcaf_pkg::S_SUM:  state_next = wcaf_pkg::S_MUL;
            wcaf_pkg::S_MUL:  state_next = wcaf_pkg::S_OUT;
            wcaf_pkg::S_OUT:  if (out_free) state_next = wcaf_pkg::S_IDLE;
            default:          state_next = wcaf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall        = 1'b1;
        ctrl.update     = 1'b0;
        ctrl.new_ge_old = new_reg >= old_value;
        load_sum        = 1'b0;
        load_prod       = 1'b0;
        load_out        = 1'b0;
        unique case (state_reg)
            wcaf_pkg::S_IDLE: in_stall = 1'b0;
            wcaf_pkg::S_RANK: ctrl.update = 1'b1;
            wcaf_pkg::S_SUM:  load_sum = 1'b1;
            wcaf_pkg::S_MUL:  load_prod = 1'b1;
            wcaf_pkg::S_OUT:  load_out = out_free;
            default:          in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wcaf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- window memory ----------------
    // Slots fill in a fixed order, so one flag tells whether the slot about
    // to be overwritten has ever held a sample.
    assign slot_next   = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign filled_next = filled_reg || (slot_next == '0);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_read_reg         <= window_mem[slot_next];
            window_mem[slot_next] <= sample;
            new_reg              <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            filled_reg    <= 1'b0;
            old_known_reg <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg      <= slot_next;
            filled_reg    <= filled_next;
            old_known_reg <= filled_reg;
        end
    end

    assign old_value = old_known_reg ? old_read_reg : '0;

    // ---------------- sorted chain ----------------
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        logic                   has_left;
        logic [SAMPLE_BITS-1:0] left_value;
        wcaf_pkg::wcaf_flags_t  left_flags;
        logic                   has_right;
        logic [SAMPLE_BITS-1:0] right_value;
        wcaf_pkg::wcaf_flags_t  right_flags;

        if (i == 0)
        begin : g_first
            assign has_left   = 1'b0;
            assign left_value = '0;
            assign left_flags = '0;
        end
        else
        begin : g_inner_left
            assign has_left   = 1'b1;
            assign left_value = cell_value[i-1];
            assign left_flags = cell_flags[i-1];
        end

        if (i == WINDOW_DEPTH - 1)
        begin : g_last
            assign has_right   = 1'b0;
            assign right_value = '0;
            assign right_flags = '0;
        end
        else
        begin : g_inner_right
            assign has_right   = 1'b1;
            assign right_value = cell_value[i+1];
            assign right_flags = cell_flags[i+1];
        end

        wcaf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .old_value   (old_value),
            .new_value   (new_reg),
            .has_left    (has_left),
            .left_value  (left_value),
            .left_flags  (left_flags),
            .has_right   (has_right),
            .right_value (right_value),
            .right_flags (right_flags),
            .value       (cell_value[i]),
            .flags       (cell_flags[i])
        );
    end

    // ---------------- centre mean ----------------
    assign sum_next = SUM_BITS'(cell_value[MID-2]) + SUM_BITS'(cell_value[MID-1])
                    + SUM_BITS'(cell_value[MID])   + SUM_BITS'(cell_value[MID+1])
                    + SUM_BITS'(cell_value[MID+2]);

    // sum / 5 as a multiply by the rounded-up reciprocal; exact for every sum
    assign quotient = prod_reg[RECIP_SHIFT +: SAMPLE_BITS];

    always_ff @(posedge clk)
    begin
        if (load_sum)
            sum_reg <= sum_next;
        if (load_prod)
            prod_reg <= PROD_BITS'(sum_reg) * PROD_BITS'(RECIP);
        if (load_out)
            out_reg <= quotient;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign filtered  = out_reg;

    // ---------------- assertions ----------------
    `WCAF_ASSERT_NEXT(a_accept_ranks, accept, state_reg == wcaf_pkg::S_RANK,
        "accepted beat did not start a chain update")

    `WCAF_ASSERT_NOW(a_centre_sorted, state_reg == wcaf_pkg::S_SUM,
        (cell_value[MID-2] <= cell_value[MID-1]) && (cell_value[MID-1] <= cell_value[MID])
        && (cell_value[MID] <= cell_value[MID+1]) && (cell_value[MID+1] <= cell_value[MID+2]),
        "centre cells out of order after update")

    `WCAF_ASSERT_NOW(a_quotient_exact, state_reg == wcaf_pkg::S_OUT,
        ((SUM_BITS'(quotient) * DIVISOR) <= sum_reg)
        && ((sum_reg - (SUM_BITS'(quotient) * DIVISOR)) < DIVISOR),
        "reciprocal multiply gave a wrong quotient")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the window centre average filter: self-checking stream test.
`timescale 1ns / 100ps

module tb_top;

    localparam int WD          = wcaf_pkg::WCAF_DEFAULT_WINDOW_DEPTH;
    localparam int SB          = wcaf_pkg::WCAF_DEFAULT_SAMPLE_BITS;
    localparam int SAMPLE_MAX  = (1 << SB) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef enum int {
        PAT_UNIFORM,
        PAT_NEAR,
        PAT_LEVEL,
        PAT_SPIKE
    } sample_pattern_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    logic          in_stall;
    logic [SB-1:0] sample    = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [SB-1:0] filtered;

    // predictor state: window history and the slot written last
    logic [SB-1:0] window_hist [WD];
    int unsigned   newest_slot;

    logic [SB-1:0] expected_filtered [$];
    int            mismatches   = 0;
    int            tx_idle_pct  = 0;
    int            rx_idle_pct  = 0;
    int            hold_left    = 0;
    int            quiet_cycles = 0;

    window_center_average_filter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered)
    );

    always #10 clk = ~clk;

    // Insert the sample, rank the window, average the five centre ranks.
    function automatic logic [SB-1:0] filter_predict(input logic [SB-1:0] value);
        logic [SB-1:0] ranked [WD];
        logic [SB-1:0] key;
        int            i;
        int            j;
        int unsigned   centre_sum;
        begin
            newest_slot = (newest_slot + 1) % WD;
            window_hist[newest_slot] = value;
            ranked = window_hist;
            for (i = 1; i < WD; i++)
            begin
                key = ranked[i];
                j = i;
                while (j > 0 && ranked[j-1] > key)
                begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = key;
            end
            centre_sum = 0;
            for (i = WD/2 - wcaf_pkg::WCAF_CENTER_HALF;
                 i <= WD/2 + wcaf_pkg::WCAF_CENTER_HALF; i++)
                centre_sum += ranked[i];
            return SB'(centre_sum / wcaf_pkg::WCAF_CENTER_COUNT);
        end
    endfunction

    // Mostly samples clustered round a level, with ties, noise and spikes mixed in.
    function automatic logic [SB-1:0] draw_sample(input logic [SB-1:0] level);
        sample_pattern_t pattern;
        int              pick;
        int              near;
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                pattern = PAT_NEAR;
            else if (pick < 60)
                pattern = PAT_LEVEL;
            else if (pick < 85)
                pattern = PAT_UNIFORM;
            else
                pattern = PAT_SPIKE;
            case (pattern)
                PAT_NEAR:
                begin
                    near = int'(level) + int'($urandom_range(16)) - 8;
                    if (near < 0)
                        near = 0;
                    if (near > SAMPLE_MAX)
                        near = SAMPLE_MAX;
                    return SB'(near);
                end
                PAT_LEVEL:
                    return level;
                PAT_SPIKE:
                    return $urandom_range(1) ? SB'(SAMPLE_MAX) : '0;
                default:
                    return SB'($urandom_range(SAMPLE_MAX));
            endcase
        end
    endfunction

    // Offer one beat and hold it until taken; the prediction is made on acceptance.
    task automatic send_sample(input logic [SB-1:0] value);
        begin
            if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid <= 1'b1;
            sample   <= value;
            do
                @(posedge clk);
            while (in_stall);
            expected_filtered.push_back(filter_predict(value));
        end
    endtask

    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (expected_filtered.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    // Full-scale samples against the zeroed window, then bit patterns and extremes.
    task automatic test_startup_extremes();
        logic [SB-1:0] pattern_list [8];
        int            n;
        begin
            tx_idle_pct = 18;
            rx_idle_pct = 18;
            pattern_list = '{'0, 12'h001, 12'h555, 12'hAAA, 12'h800, 12'h7FF,
                             12'hFFE, 12'hFFF};
            for (n = 0; n < 8; n++)
                send_sample(SB'(SAMPLE_MAX));
            for (n = 0; n < 8; n++)
                send_sample(pattern_list[n]);
        end
    endtask

    task automatic test_equal_values();
        int n;
        begin
            for (n = 0; n < 8; n++)
                send_sample(12'h3C3);
            wait_drained();
        end
    endtask

    task automatic test_random_stream(input int count);
        logic [SB-1:0] level;
        int            run_left;
        int            n;
        begin
            tx_idle_pct = 18;
            rx_idle_pct = 18;
            run_left = 0;
            level = '0;
            for (n = 0; n < count; n++)
            begin
                if (run_left == 0)
                begin
                    level = SB'($urandom_range(SAMPLE_MAX));
                    run_left = $urandom_range(16, 48);
                end
                run_left--;
                send_sample(draw_sample(level));
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering, so the input backs up.
    task automatic test_back_pressure();
        logic [SB-1:0] level;
        int            n;
        begin
            tx_idle_pct = 0;
            hold_left <= HOLD_CYCLES;
            level = SB'($urandom_range(SAMPLE_MAX));
            for (n = 0; n < 40; n++)
                send_sample(draw_sample(level));
            wait_drained();
        end
    endtask

    // No idling on either side; a full window of full scale first.
    task automatic test_no_idle();
        logic [SB-1:0] level;
        int            n;
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            for (n = 0; n < WD; n++)
                send_sample(SB'(SAMPLE_MAX));
            level = SB'($urandom_range(SAMPLE_MAX));
            for (n = 0; n < 90; n++)
                send_sample(draw_sample(level));
        end
    endtask

    // result checking and receiver stall
    always @(posedge clk)
    begin : rx_side
        logic [SB-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_filtered.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t: unexpected beat, expected none, actual filtered=%0d",
                             $time, filtered);
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (filtered !== want)
                begin
                    mismatches++;
                    if (mismatches <= 100)
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, want, filtered);
                end
            end
        end
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // watchdog: too long without any beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run
        int k;
        for (k = 0; k < WD; k++)
            window_hist[k] = '0;
        newest_slot = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_startup_extremes();
        test_equal_values();
        test_random_stream(300);
        test_back_pressure();
        test_no_idle();
        test_random_stream(160);
        wait_drained();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> window_center_average_filter_unit.f
+incdir+rtl
rtl/wcaf_pkg.sv
rtl/wcaf_cell.sv
rtl/window_center_average_filter_unit.sv
sim/tb_top.sv
